/* hdl/tcrq_pkg.sv */
// Shared constants and types for the timed command release queue.
package tcrq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int MAX_RESULTS = 32;
   localparam int REL_CNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [31:0] WINDOW_RESET = 32'd1000000;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] CMD_NOP = 3'd0;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOP_DROP = 2'd1;
   localparam logic [1:0] ST_FULL_DROP = 2'd2;
   localparam logic [1:0] ST_CLEARED = 2'd3;

   typedef struct packed {
      logic do_insert;
      logic do_clear;
      logic load_limit;
      logic pop;
      logic emit;
      logic emit_rel;
      logic [1:0] emit_status;
      logic emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic head_due;
      logic next_due;
      logic full;
   } dp_sts_type;

endpackage

/* hdl/tcrq_datapath.sv */
// Sorted shift-register queue, release limit, window register and result registers.
module tcrq_datapath
   import tcrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   input  logic [2:0]  req_cmd_type,
   input  logic [31:0] req_query_tag,
   input  logic [63:0] req_exec_time,
   input  logic [63:0] req_now_time,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_released,
   output logic [2:0]  rsp_out_type,
   output logic [31:0] rsp_out_tag,
   output logic [63:0] rsp_out_time,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [63:0] slot_time_ff [QUEUE_DEPTH];
   logic [63:0] slot_time_in [QUEUE_DEPTH];
   logic [2:0]  slot_type_ff [QUEUE_DEPTH];
   logic [2:0]  slot_type_in [QUEUE_DEPTH];
   logic [31:0] slot_tag_ff  [QUEUE_DEPTH];
   logic [31:0] slot_tag_in  [QUEUE_DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0] window_ff, window_in;
   logic [64:0] limit_ff, limit_in;

   logic [QUEUE_DEPTH-1:0] shift;

   logic        valid_ff, valid_in;
   logic        rel_ff, rel_in;
   logic [2:0]  type_ff, type_in;
   logic [31:0] tag_ff, tag_in;
   logic [63:0] time_ff, time_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;

   // A cell shifts up when its entry is later than the new one, or it is the first free cell.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         shift[i] = ((CNT_W'(i) < count_ff) && (slot_time_ff[i] > req_exec_time)) ||
                    (CNT_W'(i) == count_ff);
      end
   end

   always_comb begin
      int prv;
      int nxt;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         prv = (i == 0) ? 0 : i - 1;
         nxt = (i == QUEUE_DEPTH - 1) ? i : i + 1;
         slot_time_in[i] = slot_time_ff[i];
         slot_type_in[i] = slot_type_ff[i];
         slot_tag_in[i]  = slot_tag_ff[i];
         if (cmd.pop) begin
            slot_time_in[i] = slot_time_ff[nxt];
            slot_type_in[i] = slot_type_ff[nxt];
            slot_tag_in[i]  = slot_tag_ff[nxt];
         end else if (cmd.do_insert && shift[i]) begin
            if (i != 0 && shift[prv]) begin
               slot_time_in[i] = slot_time_ff[prv];
               slot_type_in[i] = slot_type_ff[prv];
               slot_tag_in[i]  = slot_tag_ff[prv];
            end else begin
               slot_time_in[i] = req_exec_time;
               slot_type_in[i] = req_cmd_type;
               slot_tag_in[i]  = req_query_tag;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.do_clear) begin
         count_in = '0;
      end else if (cmd.do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign window_in = csr_we ? csr_wdata : window_ff;
   assign limit_in = cmd.load_limit ? ({1'b0, req_now_time} + {33'b0, window_ff}) : limit_ff;

   assign sts.full = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign sts.head_due = (count_ff != '0) && ({1'b0, slot_time_ff[0]} < limit_ff);
   assign sts.next_due = (count_ff > CNT_W'(1)) && ({1'b0, slot_time_ff[1]} < limit_ff);

   always_comb begin
      valid_in  = cmd.emit;
      rel_in    = cmd.emit_rel;
      status_in = cmd.emit_status;
      last_in   = cmd.emit_last;
      type_in   = cmd.emit_rel ? slot_type_ff[0] : 3'd0;
      tag_in    = cmd.emit_rel ? slot_tag_ff[0] : 32'd0;
      time_in   = cmd.emit_rel ? slot_time_ff[0] : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         window_ff <= WINDOW_RESET;
         valid_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         window_ff <= window_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_time_ff[i] <= slot_time_in[i];
         slot_type_ff[i] <= slot_type_in[i];
         slot_tag_ff[i]  <= slot_tag_in[i];
      end
      limit_ff  <= limit_in;
      rel_ff    <= rel_in;
      type_ff   <= type_in;
      tag_ff    <= tag_in;
      time_ff   <= time_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_released = rel_ff;
   assign rsp_out_type = type_ff;
   assign rsp_out_tag  = tag_ff;
   assign rsp_out_time = time_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

endmodule

/* hdl/tcrq_ctrl.sv */
// Controller: decodes items and sequences tick releases one entry per cycle.
module tcrq_ctrl
   import tcrq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_cmd_type,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE    = 2'b01,
      S_RELEASE = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [REL_CNT_W-1:0] rel_cnt_ff, rel_cnt_in;
   logic accept;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      rel_cnt_in = rel_cnt_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_INSERT) begin
                  cmd.emit = 1'b1;
                  cmd.emit_last = 1'b1;
                  if (req_cmd_type == CMD_NOP) begin
                     cmd.emit_status = ST_NOP_DROP;
                  end else if (sts.full) begin
                     cmd.emit_status = ST_FULL_DROP;
                  end else begin
                     cmd.emit_status = ST_OK;
                     cmd.do_insert = 1'b1;
                  end
               end else if (req_operation == OP_TICK) begin
                  cmd.load_limit = 1'b1;
                  rel_cnt_in = '0;
                  state_in = S_RELEASE;
               end else if (req_operation == OP_CLEAR) begin
                  cmd.do_clear = 1'b1;
                  cmd.emit = 1'b1;
                  cmd.emit_last = 1'b1;
                  cmd.emit_status = ST_CLEARED;
               end else begin
                  cmd.emit = 1'b1;
                  cmd.emit_last = 1'b1;
                  cmd.emit_status = ST_OK;
               end
            end
         end
         S_RELEASE: begin
            cmd.emit = 1'b1;
            cmd.emit_status = ST_OK;
            if (!sts.head_due) begin
               // Nothing due on the first step: report an empty release.
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.pop = 1'b1;
               cmd.emit_rel = 1'b1;
               cmd.emit_last = !sts.next_due ||
                               (rel_cnt_ff == REL_CNT_W'(MAX_RESULTS - 1));
               rel_cnt_in = rel_cnt_ff + REL_CNT_W'(1);
               if (cmd.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rel_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rel_cnt_ff <= rel_cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_rel_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rel_cnt_ff <= REL_CNT_W'(MAX_RESULTS))
      else $error("release count beyond limit");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation != OP_TICK) |-> (cmd.emit && cmd.emit_last))
      else $error("non-tick item without a single final result");

   a_last_ends_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RELEASE && cmd.emit_last) |=> (state_ff == S_IDLE))
      else $error("release did not end after last result");

   a_pop_only_due: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (state_ff == S_RELEASE && sts.head_due))
      else $error("pop of an entry that is not due");
`endif

endmodule

/* hdl/timed_command_release_queue.sv */
// Top level of the timed command release queue.
// Holds up to QUEUE_DEPTH commands sorted by execution time, ties in insertion
// order. An insert, clear or unknown operation leaves busy low and its single
// result appears on the rsp_ ports in the next cycle, so such items can be
// started back to back. A release tick raises busy while the controller pops
// one entry per cycle from the head of the shift-register queue, at most 32 per
// tick; an empty release still gives one result. Results are shown for one
// cycle under rsp_valid and cannot be stalled. release_window is written
// through csr_we/csr_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce. It is sampled when a tick
// is accepted.
module timed_command_release_queue
   import tcrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_cmd_type,
   input  logic [31:0] req_query_tag,
   input  logic [63:0] req_exec_time,
   input  logic [63:0] req_now_time,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_released,
   output logic [2:0]  rsp_out_type,
   output logic [31:0] rsp_out_tag,
   output logic [63:0] rsp_out_time,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   tcrq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_cmd_type  (req_cmd_type),
      .sts           (sts),
      .cmd           (cmd)
   );

   tcrq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_cmd_type  (req_cmd_type),
      .req_query_tag (req_query_tag),
      .req_exec_time (req_exec_time),
      .req_now_time  (req_now_time),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_released  (rsp_released),
      .rsp_out_type  (rsp_out_type),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_time  (rsp_out_time),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule
